// ===== rtl/rc5_pkg.sv =====
// shared types, constants and operation codes of the rc5 cipher block
package rc5_pkg;

  localparam int WORD_W        = 16;
  localparam int ROUNDS_DEF    = 12;
  localparam int KEY_BYTES_DEF = 16;
  localparam int TABLE_DEF     = 2 * (ROUNDS_DEF + 1);
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 64;

  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [2:0]            op_t;

  // magic constants of the 16-bit key schedule
  localparam word_t P16 = 16'hb7e1;
  localparam word_t Q16 = 16'h9e37;

  // register indexes
  localparam cfg_idx_t REG_KEY_LOW  = 8'd0;
  localparam cfg_idx_t REG_KEY_HIGH = 8'd1;

  // shared unit operations
  localparam op_t OP_ADD  = 3'd0;  // x + k
  localparam op_t OP_SUB  = 3'd1;  // x - k
  localparam op_t OP_ENC  = 3'd2;  // rotl(x ^ y, y) + k
  localparam op_t OP_DEC  = 3'd3;  // rotr(x - k, y) ^ y
  localparam op_t OP_MIXA = 3'd4;  // rotl(k + x + y, 3)
  localparam op_t OP_MIXB = 3'd5;  // rotl(k + x + y, x + y)

  typedef struct packed {
    op_t   op;
    word_t x;
    word_t y;
    word_t k;
  } alu_req_t;

endpackage

// ===== rtl/rc5_in_if.sv =====
// input item channel: operation select and two block words
interface rc5_in_if;
  logic          valid;
  logic          ready;
  logic          func;
  rc5_pkg::word_t word_a;
  rc5_pkg::word_t word_b;

  modport source (output valid, output func, output word_a, output word_b, input ready);
  modport sink   (input valid, input func, input word_a, input word_b, output ready);
endinterface

// ===== rtl/rc5_out_if.sv =====
// result item channel: two result words
interface rc5_out_if;
  logic          valid;
  logic          ready;
  rc5_pkg::word_t out_a;
  rc5_pkg::word_t out_b;

  modport source (output valid, output out_a, output out_b, input ready);
  modport sink   (input valid, input out_a, input out_b, output ready);
endinterface

// ===== rtl/rc5_cfg_if.sv =====
// configuration write channel: register index and write data
interface rc5_cfg_if;
  logic               valid;
  logic               ready;
  rc5_pkg::cfg_idx_t  addr;
  rc5_pkg::cfg_data_t data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== rtl/rc5_ram.sv =====
// generic single-write, single-read ram with registered read data
module rc5_ram #(
  parameter int WIDTH = rc5_pkg::WORD_W,
  parameter int DEPTH = rc5_pkg::TABLE_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rc5_alu.sv =====
// shared 16-bit unit: add/sub, data-dependent rotate, final add or xor
module rc5_alu (
  input  rc5_pkg::alu_req_t req,
  output rc5_pkg::word_t    res
);

  rc5_pkg::word_t          sum_xy;
  rc5_pkg::word_t          pre;
  logic [3:0]              amt;
  logic [2*rc5_pkg::WORD_W-1:0] dbl;
  rc5_pkg::word_t          rot;

  always_comb begin
    sum_xy = req.x + req.y;
    pre    = req.x;
    amt    = 4'd0;
    unique case (req.op)
      rc5_pkg::OP_ADD: begin
        pre = req.x + req.k;
      end
      rc5_pkg::OP_SUB: begin
        pre = req.x - req.k;
      end
      rc5_pkg::OP_ENC: begin
        pre = req.x ^ req.y;
        amt = req.y[3:0];
      end
      rc5_pkg::OP_DEC: begin
        // right rotate as a left rotate by the complement amount
        pre = req.x - req.k;
        amt = 4'd0 - req.y[3:0];
      end
      rc5_pkg::OP_MIXA: begin
        pre = req.k + sum_xy;
        amt = 4'd3;
      end
      rc5_pkg::OP_MIXB: begin
        pre = req.k + sum_xy;
        amt = sum_xy[3:0];
      end
      default: begin
        pre = req.x;
        amt = 4'd0;
      end
    endcase

    dbl = {pre, pre} << amt;
    rot = dbl[2*rc5_pkg::WORD_W-1:rc5_pkg::WORD_W];

    if (req.op == rc5_pkg::OP_ENC) begin
      res = rot + req.k;
    end else if (req.op == rc5_pkg::OP_DEC) begin
      res = rot ^ req.y;
    end else begin
      res = rot;
    end
  end

endmodule

// ===== rtl/rc5_16bit_block_cipher.sv =====
// top level of the rc5 cipher block: key schedule and round sequencer
//
// RC5 with 16-bit words, ROUNDS rounds and a KEY_BYTES-byte key. One item
// encrypts (func 0) or decrypts (func 1) a block of two 16-bit words and
// gives one result item. The read of the first round key is issued at the
// accept edge, then one half-round per cycle runs through the shared 16-bit
// unit, bounded by the single read port of the round-key ram, and the
// result register is loaded once it is free or its result is taken. The next
// item is taken only once the block is back in idle, so items do not overlap,
// while an earlier result may still wait in the output register. After reset
// and after every key register write the round-key table is rebuilt before
// the next item is taken: the sequencer leaves idle, fills 2*(ROUNDS+1)
// table words from P and Q, then runs 3*max(2*(ROUNDS+1), key words) mixing
// steps, each a table-word step then a key-word step. Key writes are always
// taken; a key change during the rebuild runs it once more when it ends.
module rc5_16bit_block_cipher #(
  parameter int ROUNDS    = rc5_pkg::ROUNDS_DEF,
  parameter int KEY_BYTES = rc5_pkg::KEY_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rc5_in_if.sink       in_if,
  rc5_out_if.source    out_if,
  rc5_cfg_if.sink      cfg_if
);

  // table and schedule geometry
  localparam int TABLE_WORDS = 2 * (ROUNDS + 1);
  localparam int KEY_WORDS   = (KEY_BYTES + 1) / 2;
  localparam int MIX_STEPS   = 3 * ((TABLE_WORDS > KEY_WORDS) ? TABLE_WORDS : KEY_WORDS);
  localparam int IDX_W       = $clog2(TABLE_WORDS);
  localparam int KW_W        = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int STEP_W      = $clog2(MIX_STEPS);

  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(TABLE_WORDS - 1);
  localparam logic [KW_W-1:0]   KW_LAST   = KW_W'(KEY_WORDS - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MIX_STEPS - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FILL = 3'd1;  // table init from P and Q
  localparam logic [2:0] ST_MIXA = 3'd2;  // mixing step, table word
  localparam logic [2:0] ST_MIXB = 3'd3;  // mixing step, key word
  localparam logic [2:0] ST_RUN  = 3'd4;  // one half-round per cycle
  localparam logic [2:0] ST_DONE = 3'd5;  // hand result to output register

  // control state
  logic [2:0]        state_r, state_nxt;
  logic              pending_r, pending_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [KW_W-1:0]   kw_idx_r, kw_idx_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload state
  rc5_pkg::cfg_data_t key_low_r, key_high_r;
  rc5_pkg::word_t     fill_r, fill_nxt;
  rc5_pkg::word_t     a_r, a_nxt;
  rc5_pkg::word_t     b_r, b_nxt;
  logic               func_r, func_nxt;
  rc5_pkg::word_t     out_a_r, out_a_nxt;
  rc5_pkg::word_t     out_b_r, out_b_nxt;
  rc5_pkg::word_t     kw_r [KEY_WORDS];

  // key words as loaded at the start of mixing
  logic [2*rc5_pkg::CFG_DATA_W-1:0] key_bytes;
  rc5_pkg::word_t                   key_words [KEY_WORDS];

  // shared unit and table ram
  rc5_pkg::alu_req_t alu_req;
  rc5_pkg::word_t    alu_res;
  logic              ram_we;
  rc5_pkg::word_t    ram_wdata;
  rc5_pkg::word_t    ram_rdata;
  logic              key_load;
  logic              kw_we;
  logic              upd_b;
  logic              low_idx;
  logic              cfg_key_wr;

  assign in_if.ready  = (state_r == ST_IDLE) && !pending_r;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.out_a = out_a_r;
  assign out_if.out_b = out_b_r;

  assign cfg_key_wr = cfg_if.valid && cfg_if.ready &&
                      ((cfg_if.addr == rc5_pkg::REG_KEY_LOW) ||
                       (cfg_if.addr == rc5_pkg::REG_KEY_HIGH));

  // little-endian key words; a missing odd byte reads as zero
  assign key_bytes = {key_high_r, key_low_r};
  always_comb begin
    for (int m = 0; m < KEY_WORDS; m++) begin
      key_words[m][7:0]  = key_bytes[16*m +: 8];
      key_words[m][15:8] = (2 * m + 1 < KEY_BYTES) ? key_bytes[16*m+8 +: 8] : 8'h00;
    end
  end

  // odd table index updates b, even updates a
  assign upd_b   = idx_r[0];
  assign low_idx = (idx_r[IDX_W-1:1] == '0);

  always_comb begin
    state_nxt     = state_r;
    pending_nxt   = pending_r;
    idx_nxt       = idx_r;
    kw_idx_nxt    = kw_idx_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    fill_nxt      = fill_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    func_nxt      = func_r;
    out_a_nxt     = out_a_r;
    out_b_nxt     = out_b_r;
    key_load      = 1'b0;
    kw_we         = 1'b0;
    ram_we        = 1'b0;
    ram_wdata     = alu_res;
    alu_req.op    = rc5_pkg::OP_ADD;
    alu_req.x     = upd_b ? b_r : a_r;
    alu_req.y     = upd_b ? a_r : b_r;
    alu_req.k     = ram_rdata;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (pending_r) begin
          // rebuild the round-key table before any item
          state_nxt   = ST_FILL;
          pending_nxt = 1'b0;
          idx_nxt     = '0;
          fill_nxt    = rc5_pkg::P16;
        end else if (in_if.valid) begin
          state_nxt = ST_RUN;
          func_nxt  = in_if.func;
          a_nxt     = in_if.word_a;
          b_nxt     = in_if.word_b;
          idx_nxt   = in_if.func ? IDX_LAST : '0;
        end
      end
      ST_FILL: begin
        ram_we     = 1'b1;
        ram_wdata  = fill_r;
        alu_req.op = rc5_pkg::OP_ADD;
        alu_req.x  = fill_r;
        alu_req.y  = '0;
        alu_req.k  = rc5_pkg::Q16;
        fill_nxt   = alu_res;
        if (idx_r == IDX_LAST) begin
          state_nxt  = ST_MIXA;
          idx_nxt    = '0;
          kw_idx_nxt = '0;
          step_nxt   = '0;
          a_nxt      = '0;
          b_nxt      = '0;
          key_load   = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_MIXA: begin
        // table word read last cycle is mixed and written back
        alu_req.op = rc5_pkg::OP_MIXA;
        alu_req.x  = a_r;
        alu_req.y  = b_r;
        alu_req.k  = ram_rdata;
        ram_we     = 1'b1;
        ram_wdata  = alu_res;
        a_nxt      = alu_res;
        state_nxt  = ST_MIXB;
      end
      ST_MIXB: begin
        alu_req.op = rc5_pkg::OP_MIXB;
        alu_req.x  = a_r;
        alu_req.y  = b_r;
        alu_req.k  = kw_r[kw_idx_r];
        kw_we      = 1'b1;
        b_nxt      = alu_res;
        idx_nxt    = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
        kw_idx_nxt = (kw_idx_r == KW_LAST) ? '0 : kw_idx_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = ST_MIXA;
        end
      end
      ST_RUN: begin
        // whitening on the two lowest table words, full half-round elsewhere
        if (func_r) begin
          alu_req.op = low_idx ? rc5_pkg::OP_SUB : rc5_pkg::OP_DEC;
        end else begin
          alu_req.op = low_idx ? rc5_pkg::OP_ADD : rc5_pkg::OP_ENC;
        end
        if (upd_b) begin
          b_nxt = alu_res;
        end else begin
          a_nxt = alu_res;
        end
        if (idx_r == (func_r ? '0 : IDX_LAST)) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = func_r ? idx_r - 1'b1 : idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_a_nxt     = a_r;
          out_b_nxt     = b_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // a key change always forces a fresh expansion
    if (cfg_key_wr) begin
      pending_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pending_r   <= 1'b1;
      idx_r       <= '0;
      kw_idx_r    <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      key_low_r   <= '0;
      key_high_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      idx_r       <= idx_nxt;
      kw_idx_r    <= kw_idx_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.addr == rc5_pkg::REG_KEY_LOW) begin
          key_low_r <= cfg_if.data;
        end else if (cfg_if.addr == rc5_pkg::REG_KEY_HIGH) begin
          key_high_r <= cfg_if.data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    fill_r  <= fill_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    func_r  <= func_nxt;
    out_a_r <= out_a_nxt;
    out_b_r <= out_b_nxt;
    if (key_load) begin
      for (int m = 0; m < KEY_WORDS; m++) begin
        kw_r[m] <= key_words[m];
      end
    end else if (kw_we) begin
      kw_r[kw_idx_r] <= alu_res;
    end
  end

  rc5_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // read address is taken from the next-state index so the registered data is ready when used
  rc5_ram #(
    .WIDTH (rc5_pkg::WORD_W),
    .DEPTH (TABLE_WORDS)
  ) u_round_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (idx_nxt),
    .rdata (ram_rdata)
  );

  // a result only appears after the last half-round of an item
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside the done state");

  // every table-word mix is followed by its key-word mix
  a_mix_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MIXA |=> state_r == ST_MIXB)
    else $error("mixing step split");

  // the round index never leaves the table
  a_run_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN || state_r == ST_FILL || state_r == ST_MIXA) |-> idx_r <= IDX_LAST)
    else $error("table index out of range");

  // the last mixing step returns to idle
  a_mix_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MIXB && step_r == STEP_LAST) |=> state_r == ST_IDLE)
    else $error("key schedule ran past its last step");

endmodule

// ===== verif/rc5_16bit_block_cipher_test.sv =====
// testbench of the rc5 cipher block: random and directed blocks checked against a software cipher
module rc5_16bit_block_cipher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rc5_pkg::*;

  // one block of two words, as sent or as expected back
  typedef struct packed {
    word_t a;
    word_t b;
  } block_t;

  // software copy of the cipher: key registers, round-key table, expected blocks
  class rc5_ledger;
    cfg_data_t key_lo;
    cfg_data_t key_hi;
    word_t     sched[TABLE_DEF];
    block_t    pending[$];
    int        n_errors;
    int        n_checked;
    int        n_enc;
    int        n_dec;
    int        n_keys;

    function new();
      key_lo    = '0;
      key_hi    = '0;
      n_errors  = 0;
      n_checked = 0;
      n_enc     = 0;
      n_dec     = 0;
      n_keys    = 1;
      expand();
    endfunction

    function word_t rol(word_t v, word_t amt);
      int unsigned s;
      s = amt[3:0];
      if (s == 0) return v;
      return word_t'((v << s) | (v >> (WORD_W - s)));
    endfunction

    function word_t ror(word_t v, word_t amt);
      int unsigned s;
      s = amt[3:0];
      if (s == 0) return v;
      return word_t'((v >> s) | (v << (WORD_W - s)));
    endfunction

    function void expand();
      localparam int KW = (KEY_BYTES_DEF + 1) / 2;
      word_t       kw[KW];
      word_t       a;
      word_t       b;
      word_t       t;
      logic [7:0]  kb;
      int unsigned i;
      int unsigned j;
      int unsigned steps;
      for (int n = 0; n < KW; n++) kw[n] = '0;
      for (int n = 0; n < KEY_BYTES_DEF && n < 16; n++) begin
        kb = (n < 8) ? key_lo[8*n +: 8] : key_hi[8*(n-8) +: 8];
        kw[n/2] = kw[n/2] | (word_t'(kb) << (8 * (n & 1)));
      end
      sched[0] = P16;
      for (int n = 1; n < TABLE_DEF; n++) sched[n] = sched[n-1] + Q16;
      steps = 3 * ((TABLE_DEF > KW) ? TABLE_DEF : KW);
      a = '0;
      b = '0;
      i = 0;
      j = 0;
      for (int unsigned n = 0; n < steps; n++) begin
        sched[i] = rol(word_t'(sched[i] + a + b), word_t'(3));
        a = sched[i];
        t = a + b;
        kw[j] = rol(word_t'(kw[j] + a + b), t);
        b = kw[j];
        i = (i + 1) % TABLE_DEF;
        j = (j + 1) % KW;
      end
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_data_t val);
      if (idx == REG_KEY_LOW) begin
        key_lo = val;
        n_keys++;
        expand();
      end else if (idx == REG_KEY_HIGH) begin
        key_hi = val;
        n_keys++;
        expand();
      end
    endfunction

    function block_t encrypt(word_t pa, word_t pb);
      block_t r;
      word_t  a;
      word_t  b;
      a = pa + sched[0];
      b = pb + sched[1];
      for (int n = 1; n <= ROUNDS_DEF; n++) begin
        a = rol(word_t'(a ^ b), b) + sched[2*n];
        b = rol(word_t'(b ^ a), a) + sched[2*n+1];
      end
      r.a = a;
      r.b = b;
      return r;
    endfunction

    function block_t decrypt(word_t ca, word_t cb);
      block_t r;
      word_t  a;
      word_t  b;
      a = ca;
      b = cb;
      for (int n = ROUNDS_DEF; n > 0; n--) begin
        b = ror(word_t'(b - sched[2*n+1]), a) ^ a;
        a = ror(word_t'(a - sched[2*n]), b) ^ b;
      end
      r.b = b - sched[1];
      r.a = a - sched[0];
      return r;
    endfunction

    function void note_block(logic f, word_t a, word_t b);
      if (f == 1'b0) begin
        pending.push_back(encrypt(a, b));
        n_enc++;
      end else begin
        pending.push_back(decrypt(a, b));
        n_dec++;
      end
    endfunction

    function void check_words(word_t a, word_t b);
      block_t want;
      if (pending.size() == 0) begin
        $error("result %h/%h arrived with no block outstanding", a, b);
        n_errors++;
        return;
      end
      want = pending.pop_front();
      n_checked++;
      if (a !== want.a) begin
        $error("out_a mismatch: expected %h, got %h", want.a, a);
        n_errors++;
      end
      if (b !== want.b) begin
        $error("out_b mismatch: expected %h, got %h", want.b, b);
        n_errors++;
      end
    endfunction

    function void flush_check();
      if (pending.size() != 0) begin
        $error("%0d blocks never came back", pending.size());
        n_errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  rc5_in_if  in_ch ();
  rc5_out_if out_ch ();
  rc5_cfg_if cfg_ch ();

  rc5_16bit_block_cipher u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rc5_ledger book;

  // receiver idling is off in the closing phase
  bit quiet    = 1'b0;
  // request for one long hold-off on the result side
  bit hold_req = 1'b0;

  localparam int HOLD_CYCLES = 400;

  // every accepted result goes straight to the ledger
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid && out_ch.ready) begin
      book.check_words(out_ch.out_a, out_ch.out_b);
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // hold off long enough that the block fills and stops taking items
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // hard stop if the block hangs
  initial begin
    #2_000_000;
    $display("rc5_16bit_block_cipher_test NOT OK");
    $finish;
  end

  // offer one block and wait for the handshake; valid stays high on return
  task automatic send_block(logic f, word_t a, word_t b);
    in_ch.valid  <= 1'b1;
    in_ch.func   <= f;
    in_ch.word_a <= a;
    in_ch.word_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    book.note_block(f, a, b);
  endtask

  // one key register write; leaves valid low and moves past the edge
  task automatic write_key(cfg_idx_t idx, cfg_data_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    book.write_reg(idx, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // block fully drained: every expected result has come back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
  endtask

  // word biased toward the edges: zero, all ones, single set or cleared bits
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(0, 15);
      3:       return ~(word_t'(1) << $urandom_range(0, 15));
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic cfg_data_t pick_key(int kind);
    case (kind)
      0:       return '0;
      1:       return '1;
      2:       return cfg_data_t'(1) << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // random blocks; a quarter decrypt a real ciphertext so plaintext comes back
  // valid may stay high on return; the caller drops it before waiting
  task automatic run_blocks(int count, bit gaps);
    logic   f;
    block_t blk;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        f   = 1'b1;
        blk = book.encrypt(pick_word(), pick_word());
      end else begin
        f     = 1'($urandom);
        blk.a = pick_word();
        blk.b = pick_word();
      end
      send_block(f, blk.a, blk.b);
      if (gaps && $urandom_range(0, 5) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  endtask

  initial begin
    block_t blk;
    int     waited;
    book = new();

    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.func   <= 1'b0;
    in_ch.word_a <= '0;
    in_ch.word_b <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.addr  <= '0;
    cfg_ch.data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset key (all zero): word extremes both ways
    send_block(1'b0, 16'h0000, 16'h0000);
    send_block(1'b0, 16'hffff, 16'hffff);
    send_block(1'b0, 16'h0000, 16'hffff);
    send_block(1'b1, 16'h0000, 16'h0000);
    send_block(1'b1, 16'hffff, 16'hffff);
    send_block(1'b1, 16'hffff, 16'h0000);

    // all-ones key
    wait_idle();
    write_key(REG_KEY_LOW, '1);
    write_key(REG_KEY_HIGH, '1);
    send_block(1'b0, 16'h0000, 16'h0000);
    send_block(1'b0, 16'hffff, 16'hffff);
    send_block(1'b1, 16'h0000, 16'h0000);
    send_block(1'b1, 16'h8000, 16'h0001);
    blk = book.encrypt(16'h1234, 16'h5678);
    send_block(1'b1, blk.a, blk.b);

    // counting byte key; writes to unused indexes must leave it alone
    wait_idle();
    write_key(REG_KEY_LOW, 64'h0706050403020100);
    write_key(REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
    write_key(cfg_idx_t'(REG_KEY_HIGH + 1), '1);
    write_key('1, 64'h5555aaaa5555aaaa);
    send_block(1'b0, 16'h0001, 16'h8000);
    send_block(1'b0, 16'haaaa, 16'h5555);
    blk = book.encrypt(16'hfedc, 16'hba98);
    send_block(1'b1, blk.a, blk.b);
    send_block(1'b1, 16'h5555, 16'haaaa);

    // only the upper half of the key changes
    wait_idle();
    write_key(REG_KEY_HIGH, '0);
    send_block(1'b0, 16'h0000, 16'h0000);
    send_block(1'b1, 16'hffff, 16'hffff);
    send_block(1'b0, 16'h7fff, 16'h8000);

    // random phases, each under a new key setting
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case ((ph == 0) ? 0 : $urandom_range(0, 2))
        0: begin
          write_key(REG_KEY_LOW, pick_key($urandom_range(0, 5)));
          write_key(REG_KEY_HIGH, pick_key($urandom_range(0, 5)));
        end
        1: write_key(REG_KEY_LOW, pick_key($urandom_range(0, 5)));
        default: write_key(REG_KEY_HIGH, pick_key($urandom_range(0, 5)));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        write_key(cfg_idx_t'($urandom_range(REG_KEY_HIGH + 1, 255)), pick_key(3));
      end
      if (ph == 3) begin
        // long result hold-off while items keep coming back to back
        hold_req = 1'b1;
        run_blocks(40, 1'b0);
        run_blocks(200, 1'b1);
      end else if (ph == 7) begin
        // closing stretch at full rate on both sides
        quiet = 1'b1;
        run_blocks(180, 1'b0);
      end else begin
        run_blocks(240, 1'b1);
      end
    end

    // drain, then give the block a few item times to show anything extra
    in_ch.valid <= 1'b0;
    waited = 0;
    while (book.pending.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    book.flush_check();

    $display("checked %0d blocks: %0d encrypt, %0d decrypt", book.n_checked, book.n_enc,
             book.n_dec);
    $display("key settings applied: %0d, including all-zero and all-ones keys", book.n_keys);
    if (book.n_errors == 0) begin
      $display("rc5_16bit_block_cipher_test OK");
    end else begin
      $display("rc5_16bit_block_cipher_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rc5_pkg.sv
rtl/rc5_in_if.sv
rtl/rc5_out_if.sv
rtl/rc5_cfg_if.sv
rtl/rc5_ram.sv
rtl/rc5_alu.sv
rtl/rc5_16bit_block_cipher.sv
verif/rc5_16bit_block_cipher_test.sv
